[hw/rtl/linear_probe_hash_table_unit_defines.svh]
// Assertion macros shared by the hash table RTL.
// Synthesis builds define SYNTH, and then the macros expand to nothing.
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTH
// Checked at every rising clock edge, masked while reset is asserted.
`define LPHT_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lpht assertion failed");
// Implication form: the consequent is checked in the cycle after the antecedent.
`define LPHT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lpht assertion failed");
`else
`define LPHT_ASSERT(name, prop)
`define LPHT_ASSERT_NEXT(name, ante, cons)
`endif

`endif

[hw/rtl/lpht_pkg.sv]
`timescale 1ns / 1ps

package lpht_pkg;

  // Geometry
  localparam int unsigned TABLE_DEPTH = 128;
  localparam int unsigned SLOT_W      = 7;
  localparam int unsigned KEY_W       = 31;
  localparam int unsigned SIZE_W      = 8;
  localparam int unsigned BIT_W       = 5;

  // Action codes
  localparam logic [2:0] ACT_INSERT = 3'd0;
  localparam logic [2:0] ACT_SEARCH = 3'd1;
  localparam logic [2:0] ACT_REMOVE = 3'd2;
  localparam logic [2:0] ACT_READ   = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;

  // Slot state codes
  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_USED  = 2'd1;
  localparam logic [1:0] ST_GONE  = 2'd2;

  typedef struct packed {
    logic [2:0]        action;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot_index;
  } in_item_t;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot;
    logic [1:0]        slot_state;
    logic [KEY_W-1:0]  slot_key;
  } out_item_t;

  // One slot as held in the table memory
  typedef struct packed {
    logic [1:0]       state;
    logic [KEY_W-1:0] key;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_PRD,
    S_PCHK,
    S_OUT
  } state_e;

endpackage

[hw/rtl/linear_probe_hash_table_unit.sv]
`timescale 1ns / 1ps
// Insert/search/remove: bit-serial key mod size (S_MOD), then per probe a registered
// table read (S_PRD) and a check/write (S_PCHK), then the output register (S_OUT),
// which waits while out_stall_i holds back a previous word.
// Read slot: S_PRD, S_PCHK, S_OUT. Clear and unknown actions: straight to S_OUT.
// One word at a time: the next word is taken only once the unit is back in idle.
// Reset: size 128, every slot empty through per-slot valid flags; keys not reset.

`include "linear_probe_hash_table_unit_defines.svh"

module linear_probe_hash_table_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lpht_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lpht_pkg::out_item_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [7:0]           cfg_data_i
);

  localparam logic [lpht_pkg::SIZE_W-1:0] DEPTH_N = lpht_pkg::SIZE_W'(lpht_pkg::TABLE_DEPTH);

  lpht_pkg::state_e state_q, state_d;
  logic [2:0]                     act_q, act_d;
  logic [lpht_pkg::KEY_W-1:0]     key_q, key_d;
  logic [lpht_pkg::SIZE_W-1:0]    n_q, n_d;
  logic [lpht_pkg::SIZE_W-1:0]    size_q;
  logic [lpht_pkg::SLOT_W-1:0]    j_q, j_d;
  logic [lpht_pkg::BIT_W-1:0]     bit_q, bit_d;
  logic [lpht_pkg::SIZE_W-1:0]    cnt_q, cnt_d;
  logic                           hit_q, hit_d;
  logic [lpht_pkg::SLOT_W-1:0]    first_q, first_d;
  lpht_pkg::out_item_t            res_q, res_d;
  logic                           out_valid_q, out_valid_d;
  lpht_pkg::out_item_t            out_q, out_d;
  logic [lpht_pkg::TABLE_DEPTH-1:0] vld_q, vld_d;
  logic                           rd_vld_q, rd_vld_d;
  lpht_pkg::entry_t               rd_q;
  lpht_pkg::entry_t               slot_mem_q [lpht_pkg::TABLE_DEPTH];

  logic                           in_acc;
  logic                           mem_we;
  lpht_pkg::entry_t               mem_wdata;
  logic [lpht_pkg::SIZE_W-1:0]    eff_n;
  logic [1:0]                     est;
  logic                           key_hit;
  logic                           last;

  // Shared subtract/compare unit: mod step or probe wrap
  logic [lpht_pkg::SIZE_W-1:0]    unit_a;
  logic [lpht_pkg::SIZE_W:0]      unit_diff;
  logic [lpht_pkg::SIZE_W-1:0]    unit_res;

  assign unit_a    = (state_q == lpht_pkg::S_MOD) ? {j_q, key_q[bit_q]}
                                                   : ({1'b0, j_q} + 8'd1);
  assign unit_diff = {1'b0, unit_a} - {1'b0, n_q};
  assign unit_res  = unit_diff[lpht_pkg::SIZE_W] ? unit_a : unit_diff[lpht_pkg::SIZE_W-1:0];

  // Handshakes
  assign in_stall_o  = (state_q != lpht_pkg::S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Size clamp: 0 acts as 1, above depth acts as depth
  assign eff_n = (size_q == '0) ? 8'd1 : ((size_q > DEPTH_N) ? DEPTH_N : size_q);

  // Probe check terms
  assign est     = rd_vld_q ? rd_q.state : lpht_pkg::ST_EMPTY;
  assign key_hit = (est == lpht_pkg::ST_USED) && (rd_q.key == key_q);
  assign last    = ((cnt_q + 8'd1) == n_q);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    key_d       = key_q;
    n_d         = n_q;
    j_d         = j_q;
    bit_d       = bit_q;
    cnt_d       = cnt_q;
    hit_d       = hit_q;
    first_d     = first_q;
    res_d       = res_q;
    vld_d       = vld_q;
    rd_vld_d    = rd_vld_q;
    mem_we      = 1'b0;
    mem_wdata   = '0;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    unique case (state_q)
      lpht_pkg::S_IDLE: begin
        if (in_acc) begin
          act_d   = in_data_i.action;
          key_d   = in_data_i.key;
          n_d     = eff_n;
          j_d     = '0;
          bit_d   = lpht_pkg::BIT_W'(lpht_pkg::KEY_W - 1);
          cnt_d   = '0;
          hit_d   = 1'b0;
          first_d = '0;
          res_d   = '0;
          case (in_data_i.action) inside
            lpht_pkg::ACT_INSERT, lpht_pkg::ACT_SEARCH, lpht_pkg::ACT_REMOVE: begin
              state_d = lpht_pkg::S_MOD;
            end
            lpht_pkg::ACT_READ: begin
              j_d     = in_data_i.slot_index;
              state_d = lpht_pkg::S_PRD;
            end
            lpht_pkg::ACT_CLEAR: begin
              vld_d    = '0;
              res_d.ok = 1'b1;
              state_d  = lpht_pkg::S_OUT;
            end
            default: begin
              state_d = lpht_pkg::S_OUT;
            end
          endcase
        end
      end

      // One remainder bit per cycle, MSB of the key first
      lpht_pkg::S_MOD: begin
        j_d   = unit_res[lpht_pkg::SLOT_W-1:0];
        bit_d = bit_q - 5'd1;
        if (bit_q == '0) begin
          state_d = lpht_pkg::S_PRD;
        end
      end

      // Table read issued in the clocked block
      lpht_pkg::S_PRD: begin
        rd_vld_d = vld_q[j_q];
        state_d  = lpht_pkg::S_PCHK;
      end

      lpht_pkg::S_PCHK: begin
        state_d = lpht_pkg::S_OUT;
        case (act_q)
          lpht_pkg::ACT_INSERT: begin
            if (est != lpht_pkg::ST_USED) begin
              mem_we          = 1'b1;
              mem_wdata.state = lpht_pkg::ST_USED;
              mem_wdata.key   = key_q;
              vld_d[j_q]      = 1'b1;
              res_d.ok        = 1'b1;
              res_d.slot      = j_q;
            end else if (!last) begin
              state_d = lpht_pkg::S_PRD;
            end
          end
          lpht_pkg::ACT_SEARCH: begin
            if (key_hit) begin
              res_d.ok   = 1'b1;
              res_d.slot = j_q;
            end else if (est != lpht_pkg::ST_EMPTY && !last) begin
              state_d = lpht_pkg::S_PRD;
            end
          end
          lpht_pkg::ACT_REMOVE: begin
            if (key_hit) begin
              mem_we          = 1'b1;
              mem_wdata.state = lpht_pkg::ST_GONE;
              mem_wdata.key   = '0;
              vld_d[j_q]      = 1'b1;
              hit_d           = 1'b1;
              if (!hit_q) begin
                first_d = j_q;
              end
              res_d.ok   = 1'b1;
              res_d.slot = hit_q ? first_q : j_q;
              if (!last) begin
                state_d = lpht_pkg::S_PRD;
              end
            end else if (est != lpht_pkg::ST_EMPTY && !last) begin
              state_d = lpht_pkg::S_PRD;
            end else begin
              res_d.ok   = hit_q;
              res_d.slot = hit_q ? first_q : '0;
            end
          end
          lpht_pkg::ACT_READ: begin
            res_d.ok         = 1'b1;
            res_d.slot       = j_q;
            res_d.slot_state = est;
            res_d.slot_key   = (est == lpht_pkg::ST_USED) ? rd_q.key : '0;
          end
          default: begin
            res_d = '0;
          end
        endcase
        // Next probe slot, wrapping at the size
        if (state_d == lpht_pkg::S_PRD) begin
          j_d   = unit_res[lpht_pkg::SLOT_W-1:0];
          cnt_d = cnt_q + 8'd1;
        end
      end

      // Hand the word to the output register once it is free
      lpht_pkg::S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = lpht_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = lpht_pkg::S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpht_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      size_q      <= DEPTH_N;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      vld_q       <= vld_d;
      rd_vld_q    <= rd_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        size_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    key_q   <= key_d;
    n_q     <= n_d;
    j_q     <= j_d;
    bit_q   <= bit_d;
    cnt_q   <= cnt_d;
    hit_q   <= hit_d;
    first_q <= first_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  // Table memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[j_q] <= mem_wdata;
    end
    if (state_q == lpht_pkg::S_PRD) begin
      rd_q <= slot_mem_q[j_q];
    end
  end

  // Checks
  `LPHT_ASSERT(a_cnt_in_range, (state_q == lpht_pkg::S_PRD) |-> (cnt_q < n_q))
  `LPHT_ASSERT(a_home_in_range,
    (state_q == lpht_pkg::S_PRD && act_q != lpht_pkg::ACT_READ) |-> ({1'b0, j_q} < n_q))
  `LPHT_ASSERT(a_size_clamped,
    (state_q != lpht_pkg::S_IDLE) |-> (n_q != '0 && n_q <= DEPTH_N))
  `LPHT_ASSERT_NEXT(a_chk_after_rd, (state_q == lpht_pkg::S_PRD), (state_q == lpht_pkg::S_PCHK))
  `LPHT_ASSERT_NEXT(a_clear_all, (in_acc && in_data_i.action == lpht_pkg::ACT_CLEAR),
    (vld_q == '0))

endmodule

[dv/linear_probe_hash_table_unit_tb.sv]
`timescale 1ns / 1ps

module linear_probe_hash_table_unit_tb;

  // Reserved action codes: no effect, all-zero result
  localparam logic [2:0] ACT_RSVD5 = 3'd5;
  localparam logic [2:0] ACT_RSVD6 = 3'd6;
  localparam logic [2:0] ACT_RSVD7 = 3'd7;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned ITEMS_PER_PHASE = 75;
  localparam int unsigned POOL_N = 12;

  typedef struct {
    lpht_pkg::in_item_t  word;
    bit                  fixed;
    lpht_pkg::out_item_t res;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  lpht_pkg::in_item_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  lpht_pkg::out_item_t out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [7:0]          cfg_data_i = '0;

  // Shadow copy of the table
  logic [1:0]                 shadow_state [lpht_pkg::TABLE_DEPTH];
  logic [lpht_pkg::KEY_W-1:0] shadow_key   [lpht_pkg::TABLE_DEPTH];
  logic [7:0]                 shadow_size;

  lpht_pkg::out_item_t pending_results [$];
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned rx_wait = 0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;

  linear_probe_hash_table_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Timeout
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Size 0 behaves as 1, anything past the depth as the full depth
  function automatic int unsigned eff_size();
    if (shadow_size == 0) return 1;
    if (shadow_size > lpht_pkg::TABLE_DEPTH) return lpht_pkg::TABLE_DEPTH;
    return shadow_size;
  endfunction

  // Apply one word to the shadow table and return the result it produces
  function automatic lpht_pkg::out_item_t apply_table_op(lpht_pkg::in_item_t w);
    lpht_pkg::out_item_t r;
    int unsigned         n;
    int unsigned         j;
    r = '0;
    n = eff_size();
    j = w.key % n;
    case (w.action) inside
      lpht_pkg::ACT_INSERT: begin
        for (int unsigned p = 0; p < n; p++) begin
          if (shadow_state[j] != lpht_pkg::ST_USED) begin
            shadow_key[j]   = w.key;
            shadow_state[j] = lpht_pkg::ST_USED;
            r.ok   = 1'b1;
            r.slot = j[lpht_pkg::SLOT_W-1:0];
            break;
          end
          j = (j + 1 >= n) ? 0 : j + 1;
        end
      end
      lpht_pkg::ACT_SEARCH, lpht_pkg::ACT_REMOVE: begin
        for (int unsigned p = 0; p < n; p++) begin
          if (shadow_state[j] == lpht_pkg::ST_USED && shadow_key[j] == w.key) begin
            if (!r.ok) r.slot = j[lpht_pkg::SLOT_W-1:0];
            r.ok = 1'b1;
            if (w.action == lpht_pkg::ACT_SEARCH) break;
            // remove tombstones every match along the chain
            shadow_state[j] = lpht_pkg::ST_GONE;
            shadow_key[j]   = '0;
          end else if (shadow_state[j] == lpht_pkg::ST_EMPTY) begin
            break;
          end
          j = (j + 1 >= n) ? 0 : j + 1;
        end
      end
      lpht_pkg::ACT_READ: begin
        r.ok         = 1'b1;
        r.slot       = w.slot_index;
        r.slot_state = shadow_state[w.slot_index];
        r.slot_key   = (shadow_state[w.slot_index] == lpht_pkg::ST_USED) ?
                       shadow_key[w.slot_index] : '0;
      end
      lpht_pkg::ACT_CLEAR: begin
        for (int unsigned i = 0; i < lpht_pkg::TABLE_DEPTH; i++) begin
          shadow_state[i] = lpht_pkg::ST_EMPTY;
        end
        r.ok = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic lpht_pkg::out_item_t mk_res(logic ok, logic [lpht_pkg::SLOT_W-1:0] slot,
                                                 logic [1:0] st,
                                                 logic [lpht_pkg::KEY_W-1:0] k);
    lpht_pkg::out_item_t r;
    r.ok         = ok;
    r.slot       = slot;
    r.slot_state = st;
    r.slot_key   = k;
    return r;
  endfunction

  function automatic dir_row_t mk_row(logic [2:0] act, logic [lpht_pkg::KEY_W-1:0] k,
                                      logic [lpht_pkg::SLOT_W-1:0] idx, bit fixed,
                                      lpht_pkg::out_item_t res);
    dir_row_t row;
    row.word.action     = act;
    row.word.key        = k;
    row.word.slot_index = idx;
    row.fixed           = fixed;
    row.res             = res;
    return row;
  endfunction

  // Send one word; valid stays high into the next word when there is no gap
  task automatic send_word(input lpht_pkg::in_item_t w, input bit fixed,
                           input lpht_pkg::out_item_t typed);
    int unsigned         gap;
    lpht_pkg::out_item_t pred;
    gap = tx_burst ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    pred = apply_table_op(w);
    pending_results.push_back(fixed ? typed : pred);
  endtask

  // Let every outstanding result come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [7:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    cfg_valid_i <= 1'b0;
    shadow_size = v;
  endtask

  // Result side: random stall per word, check against the oldest expectation
  always @(posedge clk_i) begin : result_check
    int unsigned         w;
    lpht_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: got %h", $time, out_data_o);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.ok !== want.ok) begin
          $display("%0t: ok mismatch: expected %0d, got %0d",
                   $time, want.ok, out_data_o.ok);
          err_cnt++;
        end
        if (out_data_o.slot !== want.slot) begin
          $display("%0t: slot mismatch: expected %0d, got %0d",
                   $time, want.slot, out_data_o.slot);
          err_cnt++;
        end
        if (out_data_o.slot_state !== want.slot_state) begin
          $display("%0t: slot_state mismatch: expected %0d, got %0d",
                   $time, want.slot_state, out_data_o.slot_state);
          err_cnt++;
        end
        if (out_data_o.slot_key !== want.slot_key) begin
          $display("%0t: slot_key mismatch: expected %h, got %h",
                   $time, want.slot_key, out_data_o.slot_key);
          err_cnt++;
        end
      end
      w = rx_burst ? 0 : $urandom_range(0, 11);
      rx_wait     <= w;
      out_stall_i <= (w != 0);
    end else if (out_valid_o && rx_wait != 0) begin
      rx_wait     <= rx_wait - 1;
      out_stall_i <= (rx_wait > 1);
    end
  end

  initial begin : stimulus
    dir_row_t                   dir_tab [$];
    lpht_pkg::out_item_t        none;
    lpht_pkg::in_item_t         w;
    logic [7:0]                 sizes [$];
    logic [lpht_pkg::KEY_W-1:0] pool [POOL_N];
    int unsigned                n;
    int unsigned                pick;

    for (int unsigned i = 0; i < lpht_pkg::TABLE_DEPTH; i++) begin
      shadow_state[i] = lpht_pkg::ST_EMPTY;
      shadow_key[i]   = '0;
    end
    shadow_size = 8'd128;
    none = '0;

    // Directed words, size 128 after reset
    dir_tab.push_back(mk_row(lpht_pkg::ACT_READ, 0, 0, 1,
                             mk_res(1, 0, lpht_pkg::ST_EMPTY, 0)));
    dir_tab.push_back(mk_row(lpht_pkg::ACT_READ, 0, 127, 1,
                             mk_res(1, 127, lpht_pkg::ST_EMPTY, 0)));
    dir_tab.push_back(mk_row(lpht_pkg::ACT_SEARCH, 5, 0, 1, none));
    dir_tab.push_back(mk_row(lpht_pkg::ACT_REMOVE, 5, 0, 1, none));
    dir_tab.push_back(mk_row(ACT_RSVD5, '1, '1, 1, none));
    dir_tab.push_back(mk_row(ACT_RSVD6, 0, 0, 1, none));
    dir_tab.push_back(mk_row(ACT_RSVD7, '1, 0, 1, none));
    dir_tab.push_back(mk_row(lpht_pkg::ACT_INSERT, '1, 0, 0, none));   // home is the last slot
    dir_tab.push_back(mk_row(lpht_pkg::ACT_INSERT, 0, 0, 0, none));
    dir_tab.push_back(mk_row(lpht_pkg::ACT_INSERT, 128, 0, 0, none));  // collides at slot 0
    dir_tab.push_back(mk_row(lpht_pkg::ACT_INSERT, 255, 0, 0, none));  // wraps past the end
    dir_tab.push_back(mk_row(lpht_pkg::ACT_INSERT, 128, 0, 0, none));  // duplicate key
    dir_tab.push_back(mk_row(lpht_pkg::ACT_SEARCH, 128, 0, 0, none));
    dir_tab.push_back(mk_row(lpht_pkg::ACT_READ, 0, 127, 0, none));
    dir_tab.push_back(mk_row(lpht_pkg::ACT_REMOVE, 128, 0, 0, none));  // both copies go
    dir_tab.push_back(mk_row(lpht_pkg::ACT_READ, 0, 1, 0, none));
    dir_tab.push_back(mk_row(lpht_pkg::ACT_SEARCH, 255, 0, 0, none));  // probes past a tombstone
    dir_tab.push_back(mk_row(lpht_pkg::ACT_INSERT, 256, 0, 0, none));  // reuses a tombstone
    dir_tab.push_back(mk_row(lpht_pkg::ACT_SEARCH, 7, 0, 0, none));
    dir_tab.push_back(mk_row(lpht_pkg::ACT_READ, 0, 2, 0, none));
    dir_tab.push_back(mk_row(lpht_pkg::ACT_CLEAR, '1, '1, 1,
                             mk_res(1, 0, lpht_pkg::ST_EMPTY, 0)));
    dir_tab.push_back(mk_row(lpht_pkg::ACT_READ, 0, 2, 1,
                             mk_res(1, 2, lpht_pkg::ST_EMPTY, 0)));
    dir_tab.push_back(mk_row(lpht_pkg::ACT_SEARCH, 255, 0, 1, none));

    sizes = '{8'd1, 8'd0, 8'd2, 8'd255, 8'd200, 8'd7, 8'd128, 8'd64, 8'd33,
              8'd16, 8'd100, 8'd3};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_word(dir_tab[i].word, dir_tab[i].fixed, dir_tab[i].res);
    drain();

    // Random phases, one table size each
    foreach (sizes[s]) begin
      write_size(sizes[s]);
      n = eff_size();
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      // key pool: mostly clustered near a few home slots, some full-range keys
      for (int unsigned k = 0; k < POOL_N; k++) begin
        if ($urandom_range(0, 3) == 0) pool[k] = lpht_pkg::KEY_W'($urandom);
        else pool[k] = lpht_pkg::KEY_W'($urandom_range(0, 3) + n * $urandom_range(0, 40));
      end
      repeat (ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 38) w.action = lpht_pkg::ACT_INSERT;
        else if (pick < 63) w.action = lpht_pkg::ACT_SEARCH;
        else if (pick < 78) w.action = lpht_pkg::ACT_REMOVE;
        else if (pick < 93) w.action = lpht_pkg::ACT_READ;
        else if (pick < 96) w.action = lpht_pkg::ACT_CLEAR;
        else w.action = 3'($urandom_range(ACT_RSVD5, ACT_RSVD7));
        if ($urandom_range(0, 99) < 85) w.key = pool[$urandom_range(0, POOL_N - 1)];
        else w.key = lpht_pkg::KEY_W'($urandom);
        if ($urandom_range(0, 9) < 7) begin
          w.slot_index = lpht_pkg::SLOT_W'($urandom_range(0, n - 1));
        end else begin
          w.slot_index = lpht_pkg::SLOT_W'($urandom);
        end
        send_word(w, 1'b0, none);
      end
      drain();
    end

    // Back to reset size, then wait out any trailing activity
    write_size(8'd128);
    repeat (300) @(posedge clk_i);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/lpht_pkg.sv
hw/rtl/linear_probe_hash_table_unit.sv
dv/linear_probe_hash_table_unit_tb.sv
